### sv/pgm_p5_pkg.sv
// Shared types and constants for the binary PGM (P5) stream parser.
package pgm_p5_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_ASCII_P2  = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;
    localparam logic [2:0] ST_SIZE      = 3'd5;
    localparam logic [2:0] ST_MAXVAL    = 3'd6;
    localparam logic [2:0] ST_SHORT     = 3'd7;

    // Reset value of the side limit register
    localparam logic [14:0] MAX_SIDE_RESET = 15'd16384;

    // Parser phase
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_WIDTH   = 3'd1,
        PH_HEIGHT  = 3'd2,
        PH_MAXVAL  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // One accepted input byte or end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel;
        logic [14:0] width;
        logic [14:0] height;
        logic [2:0]  status;
        logic        last;
    } result_t;

endpackage

### sv/pgm_p5_if.sv
// Channel interfaces of the PGM parser: byte input, result output, configuration.
interface pgm_p5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pgm_p5_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel;
    logic [14:0] width;
    logic [14:0] height;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output kind, output pixel, output width, output height,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input pixel, input width, input height,
                    input status, input last, output ready);
endinterface

interface pgm_p5_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] max_side;

    modport source (output valid, output max_side, input ready);
    modport sink   (input valid, input max_side, output ready);
endinterface

### sv/pgm_p5_stream_parser.sv
// Top level of the binary PGM (P5) stream parser.
//
// Usage:
//   bytes   : one file byte per transfer, or an end_of_stream marker.
//   results : pixel (kind 0), header with width/height (kind 1) or an
//             error status (kind 2); last marks the final pixel.
//   cfg     : writes max_side, the largest accepted side; write only while
//             the parser is idle. Always ready. Sides above MAX_SIDE are refused too.
// Timing: an accepted byte is held in the input register, handled by the
//   tokenizer while held there, and its result is then registered in the
//   result register, from which it is offered. One byte is taken every
//   cycle while the result register is free; the tokenizer state update
//   is the only loop.
// Stall: when the result register holds an untaken result, the input
//   register takes a byte only if empty; that byte and all bytes after it
//   wait until the sink takes the result, whether or not they give one.
// Reset: the parser expects the magic token, no result is pending and
//   max_side returns to 16384. End of stream also returns the parser to
//   its start but keeps max_side.
module pgm_p5_stream_parser #(
    parameter int MAX_SIDE   = 16384,
    parameter int MAX_DIGITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    pgm_p5_byte_if.sink      bytes,
    pgm_p5_result_if.source  results,
    pgm_p5_cfg_if.sink       cfg
);
    import pgm_p5_pkg::*;

    logic [14:0] max_side_q_reg;
    logic [14:0] max_side_next;
    logic        item_valid;
    item_t       item;
    logic        advance;
    logic        out_free;
    logic        res_emit;
    result_t     res;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_comb
    begin
        max_side_next = max_side_q_reg;
        if (cfg.valid && cfg.ready)
        begin
            max_side_next = cfg.max_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_side_q_reg <= MAX_SIDE_RESET;
        end
        else
        begin
            max_side_q_reg <= max_side_next;
        end
    end

    pgm_p5_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pgm_p5_core #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .max_side   (max_side_q_reg),
        .out_free   (out_free),
        .advance    (advance),
        .res_emit   (res_emit),
        .res        (res)
    );

    pgm_p5_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && res_emit),
        .res     (res),
        .free    (out_free),
        .results (results)
    );

endmodule

### sv/pgm_p5_in_stage.sv
// Input register of the PGM parser: holds one accepted byte or end marker.
module pgm_p5_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    pgm_p5_byte_if.sink        bytes,
    input  logic               advance,
    output logic               item_valid,
    output pgm_p5_pkg::item_t  item
);
    import pgm_p5_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Take a new transfer when empty or when the held item moves on
    assign bytes.ready = !valid_reg || advance;
    assign load        = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte     <= bytes.data_byte;
            item_reg.end_of_stream <= bytes.end_of_stream;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/pgm_p5_core.sv
// PGM parser tokenizer and header state: one byte per cycle unless stalled.
module pgm_p5_core #(
    parameter int MAX_SIDE   = 16384,
    parameter int MAX_DIGITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  pgm_p5_pkg::item_t    item,
    input  logic [14:0]          max_side,
    input  logic                 out_free,
    output logic                 advance,
    output logic                 res_emit,
    output pgm_p5_pkg::result_t  res
);
    import pgm_p5_pkg::*;

    // Largest side that can pass the range check, and payload counter width
    localparam int LIM_MAX = (MAX_SIDE < 32767) ? MAX_SIDE : 32767;
    localparam int PIX_RAW = $clog2(LIM_MAX * LIM_MAX);
    localparam int PIX_W   = (PIX_RAW < 1) ? 1 : PIX_RAW;
    localparam logic [16:0] SIDE_CAP = 17'(MAX_SIDE);
    localparam logic [3:0]  DIGIT_CAP = 4'(MAX_DIGITS);

    localparam logic [7:0]  CH_P    = 8'h50;
    localparam logic [7:0]  CH_5    = 8'h35;
    localparam logic [7:0]  CH_2    = 8'h32;
    localparam logic [7:0]  CH_0    = 8'h30;
    localparam logic [7:0]  CH_9    = 8'h39;
    localparam logic [7:0]  CH_HASH = 8'h23;
    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  MAXVAL_OK = 8'hFF;
    localparam logic [34:0] INT_TOP = 35'h7FFFFFFF;
    localparam logic [14:0] SIDE_SAT = 15'h7FFF;

    // Magic token progress
    localparam logic [1:0] MM_NONE = 2'd0;
    localparam logic [1:0] MM_P    = 2'd1;
    localparam logic [1:0] MM_P5   = 2'd2;
    localparam logic [1:0] MM_P2   = 2'd3;

    phase_t             phase_reg, phase_next;
    logic               in_comment_reg, in_comment_next;
    logic               in_token_reg, in_token_next;
    logic [30:0]        value_reg, value_next;
    logic               ovf_reg, ovf_next;
    logic               nondigit_reg, nondigit_next;
    logic [3:0]         len_reg, len_next;
    logic [1:0]         magic_reg, magic_next;
    logic [14:0]        width_reg, width_next;
    logic [14:0]        height_reg, height_next;
    logic [PIX_W-1:0]   pixels_left_reg, pixels_left_next;

    logic [7:0]  b;
    logic        eos;
    logic        is_ws;
    logic        is_digit;

    // Token state after adding the current byte
    logic [30:0] base_value;
    logic        base_ovf;
    logic        base_nondigit;
    logic [3:0]  base_len;
    logic [1:0]  base_magic;
    logic [34:0] value_ext;
    logic [30:0] add_value;
    logic        add_ovf;
    logic        add_nondigit;
    logic [3:0]  add_len;
    logic [1:0]  add_magic;

    // Judgement of the token in hand
    logic        tok_bad;
    logic [16:0] limit;
    logic        out_of_range;
    logic [29:0] area;
    logic        fin_error;
    logic        fin_header;
    logic [2:0]  fin_status;
    phase_t      fin_phase;
    logic [14:0] fin_width;
    logic [14:0] fin_height;
    logic [PIX_W-1:0] fin_pixels;

    assign b        = item.data_byte;
    assign eos      = item.end_of_stream;
    assign advance  = item_valid && out_free;
    assign is_ws    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
                      (b == 8'h0B) || (b == 8'h0C);
    assign is_digit = (b >= CH_0) && (b <= CH_9);

    // Start from a fresh token unless one is open
    always_comb
    begin
        if (in_token_reg)
        begin
            base_value    = value_reg;
            base_ovf      = ovf_reg;
            base_nondigit = nondigit_reg;
            base_len      = len_reg;
            base_magic    = magic_reg;
        end
        else
        begin
            base_value    = '0;
            base_ovf      = 1'b0;
            base_nondigit = 1'b0;
            base_len      = '0;
            base_magic    = MM_NONE;
        end
    end

    // Value times ten plus digit
    assign value_ext = ({4'd0, base_value} << 3) + ({4'd0, base_value} << 1) +
                       {31'd0, b[3:0]};

    // Append the byte to the token
    always_comb
    begin
        add_value    = base_value;
        add_ovf      = base_ovf;
        add_nondigit = base_nondigit;
        add_magic    = base_magic;
        add_len      = (base_len == 4'hF) ? 4'hF : base_len + 4'd1;
        if (phase_reg == PH_MAGIC)
        begin
            if (add_len == 4'd1 && b == CH_P)
            begin
                add_magic = MM_P;
            end
            else if (add_len == 4'd2 && base_magic == MM_P && b == CH_5)
            begin
                add_magic = MM_P5;
            end
            else if (add_len == 4'd2 && base_magic == MM_P && b == CH_2)
            begin
                add_magic = MM_P2;
            end
            else
            begin
                add_nondigit = 1'b1;
            end
        end
        else if (!is_digit)
        begin
            add_nondigit = 1'b1;
        end
        else if (!base_ovf)
        begin
            if (value_ext > INT_TOP)
            begin
                add_ovf = 1'b1;
            end
            else
            begin
                add_value = value_ext[30:0];
            end
        end
    end

    // Size checks and payload length
    assign limit = ({2'd0, max_side} < SIDE_CAP) ? {2'd0, max_side} : SIDE_CAP;
    assign out_of_range = (width_reg == 15'd0) || (height_reg == 15'd0) ||
                          ({2'd0, width_reg} > limit) || ({2'd0, height_reg} > limit);
    assign area    = width_reg * height_reg;
    assign tok_bad = nondigit_reg || ovf_reg || (len_reg == 4'd0) || (len_reg > DIGIT_CAP);

    // Judge the open token as complete
    always_comb
    begin
        fin_error  = 1'b0;
        fin_header = 1'b0;
        fin_status = ST_OK;
        fin_phase  = phase_reg;
        fin_width  = width_reg;
        fin_height = height_reg;
        fin_pixels = pixels_left_reg;
        case (phase_reg)
            PH_MAGIC:
            begin
                if (nondigit_reg || len_reg != 4'd2 || magic_reg == MM_NONE ||
                    magic_reg == MM_P)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_BAD_MAGIC;
                end
                else if (magic_reg == MM_P2)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_ASCII_P2;
                end
                else
                begin
                    fin_phase = PH_WIDTH;
                end
            end
            PH_WIDTH:
            begin
                if (tok_bad)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_MALFORMED;
                end
                else
                begin
                    fin_width = (value_reg > {16'd0, SIDE_SAT}) ? SIDE_SAT : value_reg[14:0];
                    fin_phase = PH_HEIGHT;
                end
            end
            PH_HEIGHT:
            begin
                if (tok_bad)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_MALFORMED;
                end
                else
                begin
                    fin_height = (value_reg > {16'd0, SIDE_SAT}) ? SIDE_SAT : value_reg[14:0];
                    fin_phase  = PH_MAXVAL;
                end
            end
            PH_MAXVAL:
            begin
                if (tok_bad)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_MALFORMED;
                end
                else if (out_of_range)
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_SIZE;
                end
                else if (value_reg != {23'd0, MAXVAL_OK})
                begin
                    fin_error  = 1'b1;
                    fin_status = ST_MAXVAL;
                end
                else
                begin
                    fin_header = 1'b1;
                    fin_pixels = PIX_W'(area - 30'd1);
                    fin_phase  = PH_PAYLOAD;
                end
            end
            default:
            begin
                fin_phase = phase_reg;
            end
        endcase
        if (fin_error)
        begin
            fin_phase = PH_ERROR;
        end
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        in_comment_next  = in_comment_reg;
        in_token_next    = in_token_reg;
        value_next       = value_reg;
        ovf_next         = ovf_reg;
        nondigit_next    = nondigit_reg;
        len_next         = len_reg;
        magic_next       = magic_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        pixels_left_next = pixels_left_reg;
        if (advance)
        begin
            if (eos)
            begin
                phase_next       = PH_MAGIC;
                in_comment_next  = 1'b0;
                in_token_next    = 1'b0;
                value_next       = '0;
                ovf_next         = 1'b0;
                nondigit_next    = 1'b0;
                len_next         = '0;
                magic_next       = MM_NONE;
                width_next       = '0;
                height_next      = '0;
                pixels_left_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_ERROR, PH_DONE:
                    begin
                        phase_next = phase_reg;
                    end
                    PH_PAYLOAD:
                    begin
                        if (pixels_left_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            pixels_left_next = pixels_left_reg - PIX_W'(1);
                        end
                    end
                    default:
                    begin
                        if (in_comment_reg)
                        begin
                            if (b == CH_LF)
                            begin
                                in_comment_next = 1'b0;
                            end
                        end
                        else if (!in_token_reg && b == CH_HASH)
                        begin
                            in_comment_next = 1'b1;
                        end
                        else if (!is_ws)
                        begin
                            in_token_next = 1'b1;
                            value_next    = add_value;
                            ovf_next      = add_ovf;
                            nondigit_next = add_nondigit;
                            len_next      = add_len;
                            magic_next    = add_magic;
                        end
                        else if (in_token_reg)
                        begin
                            in_token_next    = 1'b0;
                            phase_next       = fin_phase;
                            width_next       = fin_width;
                            height_next      = fin_height;
                            pixels_left_next = fin_pixels;
                        end
                    end
                endcase
            end
        end
    end

    // Result for the item in hand
    always_comb
    begin
        res_emit = 1'b0;
        res      = '0;
        if (eos)
        begin
            case (phase_reg)
                PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                begin
                    res_emit = 1'b1;
                    res.kind = KIND_ERROR;
                    if (phase_reg == PH_MAGIC && !in_token_reg)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else if (in_token_reg && fin_error)
                    begin
                        res.status = fin_status;
                    end
                    else if (in_token_reg && fin_header)
                    begin
                        res.status = ST_SHORT;
                    end
                    else
                    begin
                        res.status = ST_MALFORMED;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_emit   = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.status = ST_SHORT;
                end
                default:
                begin
                    res_emit = 1'b0;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_emit  = 1'b1;
                    res.kind  = KIND_PIXEL;
                    res.pixel = b;
                    res.last  = (pixels_left_reg == '0);
                end
                PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                begin
                    if (!in_comment_reg && in_token_reg && is_ws)
                    begin
                        if (fin_header)
                        begin
                            res_emit   = 1'b1;
                            res.kind   = KIND_HEADER;
                            res.width  = width_reg;
                            res.height = height_reg;
                        end
                        else if (fin_error)
                        begin
                            res_emit   = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.status = fin_status;
                        end
                    end
                end
                default:
                begin
                    res_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC;
            in_comment_reg  <= 1'b0;
            in_token_reg    <= 1'b0;
            value_reg       <= '0;
            ovf_reg         <= 1'b0;
            nondigit_reg    <= 1'b0;
            len_reg         <= '0;
            magic_reg       <= MM_NONE;
            width_reg       <= '0;
            height_reg      <= '0;
            pixels_left_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            in_comment_reg  <= in_comment_next;
            in_token_reg    <= in_token_next;
            value_reg       <= value_next;
            ovf_reg         <= ovf_next;
            nondigit_reg    <= nondigit_next;
            len_reg         <= len_next;
            magic_reg       <= magic_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

endmodule

### sv/pgm_p5_out_stage.sv
// Result register of the PGM parser: holds one result until the sink takes it.
module pgm_p5_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pgm_p5_pkg::result_t  res,
    output logic                 free,
    pgm_p5_result_if.source      results
);
    import pgm_p5_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held result transfers this cycle
    assign free = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign results.valid  = valid_reg;
    assign results.kind   = res_reg.kind;
    assign results.pixel  = res_reg.pixel;
    assign results.width  = res_reg.width;
    assign results.height = res_reg.height;
    assign results.status = res_reg.status;
    assign results.last   = res_reg.last;

endmodule
